>>> src/bdf2_pkg.sv
package bdf2_pkg;

    localparam int SAMPLE_WIDTH   = 24;
    localparam int COEF_FRAC_BITS = 28;
    localparam int COEF_WIDTH     = 32;
    localparam int DELAY_BITS     = 32;
    localparam int PROD_W         = COEF_WIDTH + DELAY_BITS;
    localparam int ACC_W          = PROD_W + 2;
    localparam int SHR_W          = ACC_W - COEF_FRAC_BITS;
    localparam int TDATA_W        = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int CFG_IDX_W      = 3;
    localparam int STATE_W        = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_B0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_B1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_B2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_A1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_A2 = 3'd4;

    localparam logic signed [COEF_WIDTH-1:0] COEF_ONE =
        {{(COEF_WIDTH - COEF_FRAC_BITS - 1){1'b0}}, 1'b1, {COEF_FRAC_BITS{1'b0}}};

    localparam logic signed [ACC_W-1:0] RND_HALF =
        {{(ACC_W - COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS - 1){1'b0}}};

endpackage

>>> src/biquad_df2_filter_unit.sv
// Direct form II biquad section for signed Q1.23 audio samples with five signed
// Q4.28 coefficients (a0 normalized to one) on a plain write port; coefficients are
// to be written only while the block is idle, which the block itself does not
// enforce. One 32x32 multiplier is shared under a small sequencer. The steps are
// two feedback products, a rounding and saturation of the 32-bit internal value,
// three feedforward products and a final rounding and saturation to 24 bits.
// The input is not ready while a sample is in work; a finished result may wait in
// the output register while the next sample is taken, and the sequencer holds in
// its last step only if the previous result has not yet been transferred.
module biquad_df2_filter_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // Fields from bit 0: sample_in.
    input  logic [bdf2_pkg::TDATA_W-1:0]      i_s_axis_tdata,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // Fields from bit 0: sample_out.
    output logic [bdf2_pkg::TDATA_W-1:0]      o_m_axis_tdata,
    input  logic                              i_cfg_we,
    input  logic [bdf2_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bdf2_pkg::COEF_WIDTH-1:0]   i_cfg_data
);
    import bdf2_pkg::*;

    localparam logic [STATE_W-1:0] ST_IDLE = 4'd0;
    localparam logic [STATE_W-1:0] ST_FB1  = 4'd1;
    localparam logic [STATE_W-1:0] ST_FB2  = 4'd2;
    localparam logic [STATE_W-1:0] ST_FB3  = 4'd3;
    localparam logic [STATE_W-1:0] ST_W    = 4'd4;
    localparam logic [STATE_W-1:0] ST_FF1  = 4'd5;
    localparam logic [STATE_W-1:0] ST_FF2  = 4'd6;
    localparam logic [STATE_W-1:0] ST_FF3  = 4'd7;
    localparam logic [STATE_W-1:0] ST_OUT  = 4'd8;

    logic [STATE_W-1:0]             r_state, n_state;
    logic signed [COEF_WIDTH-1:0]   r_b0, r_b1, r_b2, r_a1, r_a2;
    logic signed [DELAY_BITS-1:0]   r_d1, r_d2, r_w;
    logic signed [PROD_W-1:0]       r_prod;
    logic signed [ACC_W-1:0]        r_acc, n_acc;
    logic [SAMPLE_WIDTH-1:0]        r_out;
    logic                           r_out_valid;

    logic signed [COEF_WIDTH-1:0]   mul_a;
    logic signed [DELAY_BITS-1:0]   mul_b;
    logic signed [ACC_W-1:0]        prod_ext;
    logic signed [ACC_W-1:0]        rnd;
    logic signed [SHR_W-1:0]        shr;
    logic signed [DELAY_BITS-1:0]   w_sat;
    logic [SAMPLE_WIDTH-1:0]        y_sat;
    logic                           in_xfer;
    logic                           out_free;
    logic [SAMPLE_WIDTH-1:0]        x_in;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = TDATA_W'(r_out);
    assign x_in            = i_s_axis_tdata[SAMPLE_WIDTH-1:0];

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_FB1: begin
                mul_a = r_a1;
                mul_b = r_d1;
            end
            ST_FB2: begin
                mul_a = r_a2;
                mul_b = r_d2;
            end
            ST_W: begin
                mul_a = r_b1;
                mul_b = r_d1;
            end
            ST_FF1: begin
                mul_a = r_b2;
                mul_b = r_d2;
            end
            ST_FF2: begin
                mul_a = r_b0;
                mul_b = r_w;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_ext = {{(ACC_W - PROD_W){r_prod[PROD_W-1]}}, r_prod};
    assign rnd      = r_acc + RND_HALF;
    assign shr      = rnd[ACC_W-1:COEF_FRAC_BITS];

    always_comb begin
        if (&shr[SHR_W-1:DELAY_BITS-1] || ~|shr[SHR_W-1:DELAY_BITS-1]) begin
            w_sat = shr[DELAY_BITS-1:0];
        end else begin
            w_sat = {shr[SHR_W-1], {(DELAY_BITS-1){~shr[SHR_W-1]}}};
        end
        if (&shr[SHR_W-1:SAMPLE_WIDTH-1] || ~|shr[SHR_W-1:SAMPLE_WIDTH-1]) begin
            y_sat = shr[SAMPLE_WIDTH-1:0];
        end else begin
            y_sat = {shr[SHR_W-1], {(SAMPLE_WIDTH-1){~shr[SHR_W-1]}}};
        end
    end

    always_comb begin
        n_state = r_state;
        n_acc   = r_acc;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_acc = {{(ACC_W - SAMPLE_WIDTH - COEF_FRAC_BITS){x_in[SAMPLE_WIDTH-1]}},
                             x_in, {COEF_FRAC_BITS{1'b0}}};
                    n_state = ST_FB1;
                end
            end
            ST_FB1: n_state = ST_FB2;
            ST_FB2: begin
                n_acc   = r_acc - prod_ext;
                n_state = ST_FB3;
            end
            ST_FB3: begin
                n_acc   = r_acc - prod_ext;
                n_state = ST_W;
            end
            ST_W: begin
                n_acc   = '0;
                n_state = ST_FF1;
            end
            ST_FF1: begin
                n_acc   = r_acc + prod_ext;
                n_state = ST_FF2;
            end
            ST_FF2: begin
                n_acc   = r_acc + prod_ext;
                n_state = ST_FF3;
            end
            ST_FF3: begin
                n_acc   = r_acc + prod_ext;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        r_acc  <= n_acc;
        if (r_state == ST_W) begin
            r_w <= w_sat;
        end
        if (r_state == ST_OUT && out_free) begin
            r_out <= y_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_d1        <= '0;
            r_d2        <= '0;
            r_b0        <= COEF_ONE;
            r_b1        <= '0;
            r_b2        <= '0;
            r_a1        <= '0;
            r_a2        <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_OUT && out_free) begin
                r_out_valid <= 1'b1;
                r_d2        <= r_d1;
                r_d1        <= r_w;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_B0:  r_b0 <= i_cfg_data;
                    CFG_B1:  r_b1 <= i_cfg_data;
                    CFG_B2:  r_b2 <= i_cfg_data;
                    CFG_A1:  r_a1 <= i_cfg_data;
                    CFG_A2:  r_a2 <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

>>> dv/tb_biquad_df2_filter_unit.sv
module tb_biquad_df2_filter_unit;

    import bdf2_pkg::*;

    localparam int          CYCLE_LIMIT = 200000;
    localparam int unsigned QUIET_FROM  = 250;
    localparam int unsigned QUIET_TO    = 380;
    localparam int unsigned PRESSURE_AT = 120;
    localparam int unsigned HOLD_CYCLES = 300;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic signed [COEF_WIDTH-1:0]   coef_t;
    typedef logic signed [79:0]             wide_t;

    typedef struct {
        coef_t b0;
        coef_t b1;
        coef_t b2;
        coef_t a1;
        coef_t a2;
    } coef_set_t;

    class biquad_scoreboard;
        coef_set_t            coefs;
        logic signed [31:0]   delay_one;
        logic signed [31:0]   delay_two;
        sample_t              expected_out[$];
        int unsigned          errors;

        function new();
            coefs     = '{COEF_ONE, 0, 0, 0, 0};
            delay_one = '0;
            delay_two = '0;
            errors    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, coef_t v);
            case (idx)
                CFG_B0: coefs.b0 = v;
                CFG_B1: coefs.b1 = v;
                CFG_B2: coefs.b2 = v;
                CFG_A1: coefs.a1 = v;
                CFG_A2: coefs.a2 = v;
                default: ;
            endcase
        endfunction

        function wide_t round_frac(wide_t v);
            return (v + (wide_t'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
        endfunction

        function wide_t clamp(wide_t v, int bits);
            wide_t hi;
            wide_t lo;
            hi = (wide_t'(1) <<< (bits - 1)) - 1;
            lo = -hi - 1;
            if (v > hi) return hi;
            if (v < lo) return lo;
            return v;
        endfunction

        function void note_sample(sample_t x);
            wide_t xs, d1, d2, b0, b1, b2, a1, a2, w, y;
            xs = x;
            d1 = delay_one;
            d2 = delay_two;
            b0 = coefs.b0;
            b1 = coefs.b1;
            b2 = coefs.b2;
            a1 = coefs.a1;
            a2 = coefs.a2;
            w = clamp(round_frac((xs <<< COEF_FRAC_BITS) - a1 * d1 - a2 * d2), DELAY_BITS);
            y = clamp(round_frac(b0 * w + b1 * d1 + b2 * d2), SAMPLE_WIDTH);
            delay_two = delay_one;
            delay_one = w[31:0];
            expected_out.push_back(y[SAMPLE_WIDTH-1:0]);
        endfunction

        function void check_result(sample_t got);
            sample_t want;
            if (expected_out.size() == 0) begin
                if (errors < 10)
                    $display("sample_out %0d arrived with nothing pending", got);
                errors++;
                return;
            end
            want = expected_out.pop_front();
            if (got !== want) begin
                if (errors < 10)
                    $display("sample_out mismatch: expected %0d, got %0d", want, got);
                errors++;
            end
        endfunction

        function int outstanding();
            return expected_out.size();
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [TDATA_W-1:0]     i_s_axis_tdata = '0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]     o_m_axis_tdata;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [COEF_WIDTH-1:0]  i_cfg_data = '0;

    biquad_scoreboard board = new();
    int unsigned      samples_sent = 0;
    int               cycles = 0;

    biquad_df2_filter_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("biquad_df2_filter_unit regression: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            board.check_result(sample_t'(o_m_axis_tdata[SAMPLE_WIDTH-1:0]));
    end

    // The sink stalls at random, except for one quiet stretch, and once holds off
    // long enough for the filter to back up into its input.
    initial begin : result_sink
        int unsigned taken;
        int unsigned hold_left;
        bit          held;
        taken     = 0;
        hold_left = 0;
        held      = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
                taken++;
            if (!held && taken == PRESSURE_AT) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= (taken >= QUIET_FROM && taken < QUIET_TO) ||
                                   ($urandom_range(99) >= 20);
            end
        end
    end

    task automatic send_sample(input sample_t x);
        logic [TDATA_W-1:0] word;
        word = '0;
        word[SAMPLE_WIDTH-1:0] = x;
        while (!(samples_sent >= QUIET_FROM && samples_sent < QUIET_TO) &&
               $urandom_range(99) < 20) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= word;
        do @(posedge i_clk); while (!o_s_axis_tready);
        board.note_sample(x);
        samples_sent++;
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (board.outstanding() != 0) @(posedge i_clk);
    endtask

    task automatic poke_coef(input logic [CFG_IDX_W-1:0] idx, input coef_t v);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        @(posedge i_clk);
        board.write_reg(idx, v);
    endtask

    task automatic program_filter(input coef_set_t c, input bit stray);
        drain();
        poke_coef(CFG_B0, c.b0);
        poke_coef(CFG_B1, c.b1);
        poke_coef(CFG_B2, c.b2);
        poke_coef(CFG_A1, c.a1);
        poke_coef(CFG_A2, c.a2);
        // Indexes past the last register must leave every coefficient alone.
        if (stray)
            poke_coef(CFG_IDX_W'($urandom_range(2 ** CFG_IDX_W - 1, CFG_A2 + 1)),
                      coef_t'($urandom()));
        i_cfg_we <= 1'b0;
    endtask

    function automatic coef_t random_coef(input bit wild, input int unsigned span);
        if (wild)
            return coef_t'($urandom());
        return coef_t'(int'($urandom_range(2 * span, 0)) - int'(span));
    endfunction

    function automatic coef_set_t random_set(input bit wild);
        coef_set_t c;
        c.b0 = random_coef(wild, 32'd536870912);
        c.b1 = random_coef(wild, 32'd536870912);
        c.b2 = random_coef(wild, 32'd268435456);
        c.a1 = random_coef(wild, 32'd510027366);
        c.a2 = random_coef(wild, 32'd241591910);
        return c;
    endfunction

    function automatic sample_t random_sample();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 10)
            return pick[0] ? sample_t'(24'sh7FFFFF) : sample_t'(24'sh800000);
        if (pick < 25)
            return sample_t'(int'($urandom_range(32, 0)) - 16);
        return sample_t'($urandom());
    endfunction

    initial begin : stimulus
        sample_t pts[$];
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset coefficients pass the sample straight through.
        pts = '{24'sh000000, 24'sh7FFFFF, 24'sh800000, 24'shFFFFFF, 24'sh000001,
                24'sh555555, 24'shAAAAAA};
        foreach (pts[i]) send_sample(pts[i]);

        // A gain of one half puts odd samples exactly on the rounding midpoint.
        program_filter('{32'sh08000000, 0, 0, 0, 0}, 1'b1);
        pts = '{24'sh000001, 24'shFFFFFF, 24'sh000003, 24'shFFFFFD};
        foreach (pts[i]) send_sample(pts[i]);

        // Extreme coefficients drive the internal value and the output into saturation.
        program_filter('{32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000,
                         32'sh7FFFFFFF}, 1'b1);
        pts = '{24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF,
                24'sh000000};
        foreach (pts[i]) send_sample(pts[i]);

        program_filter('{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                         32'sh80000000}, 1'b0);
        pts = '{24'sh800000, 24'sh7FFFFF, 24'sh000000, 24'shFFFFFF};
        foreach (pts[i]) send_sample(pts[i]);

        for (int p = 0; p < 10; p++) begin
            program_filter(random_set(p % 3 == 1), p % 2 == 0);
            repeat (53) send_sample(random_sample());
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (board.errors == 0 && board.outstanding() == 0)
            $display("biquad_df2_filter_unit regression: pass");
        else
            $display("biquad_df2_filter_unit regression: fail");
        $finish;
    end

endmodule
